// File: src/prac_pkg.sv
// Shared types, constants and saturation helpers for the plate reverb.
package prac_pkg;

  localparam int POS_W    = 11;
  localparam int SAMPLE_W = 24;
  localparam int DATA_W   = 32;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = 50;
  localparam int CFG_IDX_W = 3;

  localparam int ALLPASS_ONE_LEN_DEF   = 150;
  localparam int ALLPASS_TWO_LEN_DEF   = 190;
  localparam int ALLPASS_THREE_LEN_DEF = 264;
  localparam int COMB_ONE_LEN_DEF      = 919;
  localparam int COMB_TWO_LEN_DEF      = 1179;

  // Fixed allpass gains 0.6, 0.65, 0.7 in Q0.16.
  localparam logic [GAIN_W-1:0] AP_GAIN_ONE   = 16'd39322;
  localparam logic [GAIN_W-1:0] AP_GAIN_TWO   = 16'd42598;
  localparam logic [GAIN_W-1:0] AP_GAIN_THREE = 16'd45875;

  localparam logic [GAIN_W-1:0] COMB_GAIN_FIRST_RST  = 16'd62187;
  localparam logic [GAIN_W-1:0] COMB_GAIN_SECOND_RST = 16'd61263;
  localparam logic [GAIN_W-1:0] LOWPASS_COEF_RST     = 16'd13625;
  localparam logic [GAIN_W-1:0] WET_MIX_RST          = 16'd8192;
  localparam logic [GAIN_W-1:0] WET_UNITY            = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_COMB_GAIN_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_GAIN_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_COEF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_ENABLE    = 3'd4;

  localparam logic [2:0] LINE_AP1 = 3'd0;
  localparam logic [2:0] LINE_AP2 = 3'd1;
  localparam logic [2:0] LINE_AP3 = 3'd2;
  localparam logic [2:0] LINE_CB1 = 3'd3;
  localparam logic [2:0] LINE_CB2 = 3'd4;

  localparam logic signed [PROD_W-1:0] S32_MAX   = 50'sh0_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] S32_MIN   = 50'sh3_FFFF_8000_0000;
  localparam logic signed [PROD_W-1:0] S24_MAX   = 50'sh0_0000_007F_FFFF;
  localparam logic signed [PROD_W-1:0] S24_MIN   = 50'sh3_FFFF_FF80_0000;
  localparam logic signed [PROD_W-1:0] ROUND_16  = 50'sd32768;
  localparam logic signed [PROD_W-1:0] ROUND_15  = 50'sd16384;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR,
    OP_AP_RD, OP_AP_OUT, OP_AP_MUL, OP_AP_WR,
    OP_CB_RD, OP_CB_MUL, OP_CB_WR,
    OP_LP_M1, OP_LP_M2, OP_LP_END,
    OP_MX_M1, OP_MX_M2, OP_MX_END,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       side;
    logic [2:0] line;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    r = v;
    if (v > S32_MAX) r = S32_MAX;
    if (v < S32_MIN) r = S32_MIN;
    return r[DATA_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    r = v;
    if (v > S24_MAX) r = S24_MAX;
    if (v < S24_MIN) r = S24_MIN;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [PROD_W-1:0] ext32(input logic signed [DATA_W-1:0] v);
    return {{(PROD_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

// File: src/prac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/prac_ctrl.sv
// Sequencer for the reverb: clearing pass, per-side step schedule, result hand-off.
module prac_ctrl
  import prac_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;
  localparam logic [4:0] LAST_STEP = 5'd23;

  logic [1:0] state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       side_q, side_d;
  op_e        step_op;
  logic [2:0] step_line;

  // Map a step of one side to its operation and delay line.
  always_comb begin
    step_op   = OP_NONE;
    step_line = LINE_AP1;
    if (step_q < 5'd12) begin
      step_line = {1'b0, step_q[3:2]};
      case (step_q[1:0])
        2'd0:    step_op = OP_AP_RD;
        2'd1:    step_op = OP_AP_OUT;
        2'd2:    step_op = OP_AP_MUL;
        default: step_op = OP_AP_WR;
      endcase
    end else begin
      case (step_q)
        5'd12: begin step_op = OP_CB_RD;  step_line = LINE_CB1; end
        5'd13: begin step_op = OP_CB_MUL; step_line = LINE_CB1; end
        5'd14: begin step_op = OP_CB_WR;  step_line = LINE_CB1; end
        5'd15: begin step_op = OP_CB_RD;  step_line = LINE_CB2; end
        5'd16: begin step_op = OP_CB_MUL; step_line = LINE_CB2; end
        5'd17: begin step_op = OP_CB_WR;  step_line = LINE_CB2; end
        5'd18: step_op = OP_LP_M1;
        5'd19: step_op = OP_LP_M2;
        5'd20: step_op = OP_LP_END;
        5'd21: step_op = OP_MX_M1;
        5'd22: step_op = OP_MX_M2;
        5'd23: step_op = OP_MX_END;
        default: step_op = OP_NONE;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    side_d     = side_q;
    cmd_o      = '{op: OP_NONE, side: side_q, line: step_line, load: 1'b0};
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (st_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          step_d     = '0;
          side_d     = 1'b0;
        end
      end
      ST_RUN: begin
        cmd_o.op = step_op;
        if (step_q == LAST_STEP) begin
          step_d = '0;
          if (side_q) begin
            state_d = ST_FINISH;
          end else begin
            side_d = 1'b1;
          end
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_FINISH: begin
        // Hold until the output register can take the word.
        if (st_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= '0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      side_q  <= side_d;
    end
  end

`ifndef SYNTHESIS
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_RUN && step_q == 5'd0 && !side_q))
    else $error("load did not start the schedule");
  a_run_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> (state_q == ST_RUN || state_q == ST_FINISH))
    else $error("schedule left without finishing");
  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !st_i.out_free) |=> (state_q == ST_FINISH))
    else $error("result handed off while output busy");
`endif

endmodule

// File: src/prac_dp.sv
// Datapath: delay memories, positions, shared multiplier, config and output registers.
module prac_dp
  import prac_pkg::*;
#(
  parameter int ALLPASS_ONE_LEN   = ALLPASS_ONE_LEN_DEF,
  parameter int ALLPASS_TWO_LEN   = ALLPASS_TWO_LEN_DEF,
  parameter int ALLPASS_THREE_LEN = ALLPASS_THREE_LEN_DEF,
  parameter int COMB_ONE_LEN      = COMB_ONE_LEN_DEF,
  parameter int COMB_TWO_LEN      = COMB_TWO_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    st_o,
  input  logic signed [SAMPLE_W-1:0] left_sample_i,
  input  logic signed [SAMPLE_W-1:0] right_sample_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [GAIN_W-1:0]          cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] left_result_o,
  output logic signed [SAMPLE_W-1:0] right_result_o
);

  localparam int AP_SIDE   = ALLPASS_ONE_LEN + ALLPASS_TWO_LEN + ALLPASS_THREE_LEN;
  localparam int CB_SIDE   = COMB_ONE_LEN + COMB_TWO_LEN;
  localparam int AP_DEPTH  = 2 * AP_SIDE;
  localparam int CB_DEPTH  = 2 * CB_SIDE;
  localparam int AP_AW     = $clog2(AP_DEPTH);
  localparam int CB_AW     = $clog2(CB_DEPTH);
  localparam int CLR_DEPTH = (AP_DEPTH > CB_DEPTH) ? AP_DEPTH : CB_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam logic [POS_W:0] LEN_AP1 = (POS_W+1)'(ALLPASS_ONE_LEN);
  localparam logic [POS_W:0] LEN_AP2 = (POS_W+1)'(ALLPASS_TWO_LEN);
  localparam logic [POS_W:0] LEN_AP3 = (POS_W+1)'(ALLPASS_THREE_LEN);
  localparam logic [POS_W:0] LEN_CB1 = (POS_W+1)'(COMB_ONE_LEN);
  localparam logic [POS_W:0] LEN_CB2 = (POS_W+1)'(COMB_TWO_LEN);

  // Configuration registers.
  logic [GAIN_W-1:0] comb_gain_first_q, comb_gain_second_q, lowpass_coef_q, wet_mix_q;
  logic              stereo_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comb_gain_first_q  <= COMB_GAIN_FIRST_RST;
      comb_gain_second_q <= COMB_GAIN_SECOND_RST;
      lowpass_coef_q     <= LOWPASS_COEF_RST;
      wet_mix_q          <= WET_MIX_RST;
      stereo_enable_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COMB_GAIN_FIRST:  comb_gain_first_q  <= cfg_data_i;
        CFG_COMB_GAIN_SECOND: comb_gain_second_q <= cfg_data_i;
        CFG_LOWPASS_COEF:     lowpass_coef_q     <= cfg_data_i;
        CFG_WET_MIX:          wet_mix_q          <= cfg_data_i;
        CFG_STEREO_ENABLE:    stereo_enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [GAIN_W-1:0] wet_c, dry_c;
  assign wet_c = (wet_mix_q > WET_UNITY) ? WET_UNITY : wet_mix_q;
  assign dry_c = WET_UNITY - wet_c;

  // Line positions, shared by both sides.
  logic [POS_W-1:0] pos_q [5];
  logic [POS_W:0]   len_v [5];
  assign len_v[0] = LEN_AP1;
  assign len_v[1] = LEN_AP2;
  assign len_v[2] = LEN_AP3;
  assign len_v[3] = LEN_CB1;
  assign len_v[4] = LEN_CB2;

  for (genvar k = 0; k < 5; k++) begin : g_pos
    logic [POS_W:0] nxt;
    assign nxt = {1'b0, pos_q[k]} + 1'b1;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q[k] <= '0;
      end else if (cmd_i.op == OP_FINISH) begin
        pos_q[k] <= (nxt >= len_v[k]) ? '0 : nxt[POS_W-1:0];
      end
    end
  end

  logic [POS_W-1:0]  cur_pos;
  logic [POS_W:0]    cur_len;
  logic [AP_AW-1:0]  ap_off;
  logic [CB_AW-1:0]  cb_off;
  logic [GAIN_W-1:0] ap_gain, cb_gain;

  always_comb begin
    cur_pos = pos_q[0];
    cur_len = LEN_AP1;
    ap_off  = '0;
    cb_off  = '0;
    ap_gain = AP_GAIN_ONE;
    cb_gain = comb_gain_first_q;
    case (cmd_i.line)
      LINE_AP1: ;
      LINE_AP2: begin
        cur_pos = pos_q[1]; cur_len = LEN_AP2;
        ap_off  = AP_AW'(ALLPASS_ONE_LEN); ap_gain = AP_GAIN_TWO;
      end
      LINE_AP3: begin
        cur_pos = pos_q[2]; cur_len = LEN_AP3;
        ap_off  = AP_AW'(ALLPASS_ONE_LEN + ALLPASS_TWO_LEN); ap_gain = AP_GAIN_THREE;
      end
      LINE_CB1: begin
        cur_pos = pos_q[3]; cur_len = LEN_CB1;
      end
      LINE_CB2: begin
        cur_pos = pos_q[4]; cur_len = LEN_CB2;
        cb_off  = CB_AW'(COMB_ONE_LEN); cb_gain = comb_gain_second_q;
      end
      default: ;
    endcase
  end

  // Read one cell ahead of the write position, wrapping at the line end.
  logic [POS_W:0]   rd_nxt;
  logic [POS_W-1:0] rd_idx;
  assign rd_nxt = {1'b0, cur_pos} + 1'b1;
  assign rd_idx = (rd_nxt >= cur_len) ? '0 : rd_nxt[POS_W-1:0];

  logic [AP_AW-1:0] ap_base;
  logic [CB_AW-1:0] cb_base;
  assign ap_base = (cmd_i.side ? AP_AW'(AP_SIDE) : '0) + ap_off;
  assign cb_base = (cmd_i.side ? CB_AW'(CB_SIDE) : '0) + cb_off;

  // Clearing pass counter.
  logic [CLR_W-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.op == OP_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end
  assign st_o.clr_last = (clr_q == CLR_W'(CLR_DEPTH - 1));

  logic              clr_op;
  assign clr_op = (cmd_i.op == OP_CLEAR);

  // Signal registers.
  logic signed [DATA_W-1:0]   y_q, out_q, lp_l_q, lp_r_q, cur_lp;
  logic signed [SAMPLE_W-1:0] x_l_q, x_r_q, res_l_q, res_r_q, cur_x;
  logic signed [DATA_W:0]     sum_q;
  logic signed [PROD_W-1:0]   prod_q, acc_q, prod_d;
  logic signed [DATA_W-1:0]   ap_rdata, cb_rdata;
  logic signed [DATA_W-1:0]   mul_a;
  logic [GAIN_W:0]            mul_b;
  logic signed [GAIN_W+1:0]   mul_b_s;

  assign cur_lp = cmd_i.side ? lp_r_q : lp_l_q;
  assign cur_x  = cmd_i.side ? x_r_q : x_l_q;

  always_comb begin
    mul_a = y_q;
    mul_b = '0;
    case (cmd_i.op)
      OP_AP_RD:  begin mul_a = y_q;      mul_b = {1'b0, ap_gain}; end
      OP_AP_MUL: begin mul_a = out_q;    mul_b = {1'b0, ap_gain}; end
      OP_CB_MUL: begin mul_a = cb_rdata; mul_b = {1'b0, cb_gain}; end
      OP_LP_M1: begin
        mul_a = sum_q[DATA_W:1];
        mul_b = (GAIN_W+1)'(2**GAIN_W) - {1'b0, lowpass_coef_q};
      end
      OP_LP_M2:  begin mul_a = cur_lp;   mul_b = {1'b0, lowpass_coef_q}; end
      OP_MX_M1: begin
        mul_a = {{(DATA_W-SAMPLE_W){cur_x[SAMPLE_W-1]}}, cur_x};
        mul_b = {1'b0, dry_c};
      end
      OP_MX_M2:  begin mul_a = cur_lp;   mul_b = {1'b0, wet_c}; end
      default: ;
    endcase
  end

  assign mul_b_s = {1'b0, mul_b};
  assign prod_d  = mul_a * mul_b_s;

  logic signed [PROD_W-1:0] rnd16, fin16, fin15;
  logic signed [DATA_W-1:0] ap_out_v, line_wr_v;
  assign rnd16     = (prod_q + ROUND_16) >>> 16;
  assign fin16     = (acc_q + prod_q + ROUND_16) >>> 16;
  assign fin15     = (acc_q + prod_q + ROUND_15) >>> 15;
  assign ap_out_v  = sat32(ext32(ap_rdata) - rnd16);
  assign line_wr_v = sat32(ext32(y_q) + rnd16);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      x_l_q <= left_sample_i;
      x_r_q <= stereo_enable_q ? right_sample_i : left_sample_i;
      y_q   <= {{(DATA_W-SAMPLE_W){left_sample_i[SAMPLE_W-1]}}, left_sample_i};
    end
    case (cmd_i.op)
      OP_AP_OUT: out_q <= ap_out_v;
      OP_AP_WR:  y_q   <= out_q;
      OP_CB_MUL: begin
        if (cmd_i.line == LINE_CB1) begin
          sum_q <= {cb_rdata[DATA_W-1], cb_rdata};
        end else begin
          sum_q <= sum_q + {cb_rdata[DATA_W-1], cb_rdata};
        end
      end
      OP_LP_M2, OP_MX_M2: acc_q <= prod_q;
      OP_MX_END: begin
        if (cmd_i.side) begin
          res_r_q <= sat24(fin15);
        end else begin
          res_l_q <= sat24(fin15);
          // Start the right side from its input.
          y_q     <= {{(DATA_W-SAMPLE_W){x_r_q[SAMPLE_W-1]}}, x_r_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_l_q <= '0;
      lp_r_q <= '0;
    end else if (cmd_i.op == OP_LP_END) begin
      if (cmd_i.side) lp_r_q <= sat32(fin16);
      else            lp_l_q <= sat32(fin16);
    end
  end

  // Memories.
  logic             ap_we, cb_we;
  logic [AP_AW-1:0] ap_waddr, ap_raddr;
  logic [CB_AW-1:0] cb_waddr, cb_raddr;
  logic [DATA_W-1:0] ap_wdata, cb_wdata;

  assign ap_we    = (cmd_i.op == OP_AP_WR) ||
                    (clr_op && ({1'b0, clr_q} < (CLR_W+1)'(AP_DEPTH)));
  assign cb_we    = (cmd_i.op == OP_CB_WR) ||
                    (clr_op && ({1'b0, clr_q} < (CLR_W+1)'(CB_DEPTH)));
  assign ap_waddr = clr_op ? clr_q[AP_AW-1:0] : ap_base + AP_AW'(cur_pos);
  assign cb_waddr = clr_op ? clr_q[CB_AW-1:0] : cb_base + CB_AW'(cur_pos);
  assign ap_raddr = ap_base + AP_AW'(rd_idx);
  assign cb_raddr = cb_base + CB_AW'(rd_idx);
  assign ap_wdata = clr_op ? '0 : line_wr_v;
  assign cb_wdata = clr_op ? '0 : line_wr_v;

  prac_ram #(.WIDTH(DATA_W), .DEPTH(AP_DEPTH)) u_ap_ram (
    .clk_i   (clk_i),
    .we_i    (ap_we),
    .waddr_i (ap_waddr),
    .wdata_i (ap_wdata),
    .raddr_i (ap_raddr),
    .rdata_o (ap_rdata)
  );

  prac_ram #(.WIDTH(DATA_W), .DEPTH(CB_DEPTH)) u_cb_ram (
    .clk_i   (clk_i),
    .we_i    (cb_we),
    .waddr_i (cb_waddr),
    .wdata_i (cb_wdata),
    .raddr_i (cb_raddr),
    .rdata_o (cb_rdata)
  );

  // Output register.
  logic ovalid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.op == OP_FINISH) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH) begin
      left_result_o  <= res_l_q;
      right_result_o <= res_r_q;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign st_o.out_free = !ovalid_q || !out_stall_i;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pos_q[0]} < LEN_AP1) && ({1'b0, pos_q[1]} < LEN_AP2) &&
    ({1'b0, pos_q[2]} < LEN_AP3) && ({1'b0, pos_q[3]} < LEN_CB1) &&
    ({1'b0, pos_q[4]} < LEN_CB2))
    else $error("line position out of range");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FINISH) |-> (!ovalid_q || !out_stall_i))
    else $error("output overwritten while held");
`endif

endmodule

// File: src/plate_reverb_allpass_comb.sv
// Stereo plate reverb: three allpasses, two feedback combs, lowpass and dry/wet mix per side.
//
// Each input word is processed in full before the next word can be accepted: one
// shared 32x17 multiplier and the one read and one write port of each delay memory
// are stepped through 24 operations per side, then a finishing step, held until the
// output register is free, hands the pair to it; the register holds it while the next
// word is taken. After reset a clearing pass zeroes the delay memories, one cell per
// cycle, over 2*(COMB_ONE_LEN+COMB_TWO_LEN) cells (4196 at the default lengths), or
// 2*(sum of allpass lengths) cells if that is larger; no word is accepted during it,
// while configuration writes are taken at any time.
module plate_reverb_allpass_comb
  import prac_pkg::*;
#(
  parameter int ALLPASS_ONE_LEN   = ALLPASS_ONE_LEN_DEF,
  parameter int ALLPASS_TWO_LEN   = ALLPASS_TWO_LEN_DEF,
  parameter int ALLPASS_THREE_LEN = ALLPASS_THREE_LEN_DEF,
  parameter int COMB_ONE_LEN      = COMB_ONE_LEN_DEF,
  parameter int COMB_TWO_LEN      = COMB_TWO_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] left_sample_i,
  input  logic signed [SAMPLE_W-1:0] right_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] left_result_o,
  output logic signed [SAMPLE_W-1:0] right_result_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [GAIN_W-1:0]          cfg_data_i
);

  cmd_t    cmd;
  status_t st;

  prac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  prac_dp #(
    .ALLPASS_ONE_LEN   (ALLPASS_ONE_LEN),
    .ALLPASS_TWO_LEN   (ALLPASS_TWO_LEN),
    .ALLPASS_THREE_LEN (ALLPASS_THREE_LEN),
    .COMB_ONE_LEN      (COMB_ONE_LEN),
    .COMB_TWO_LEN      (COMB_TWO_LEN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_result_o  (left_result_o),
    .right_result_o (right_result_o)
  );

endmodule
